[src/bst_pkg.sv]
// ----------------------------------------------------------------------------
// Bounded set table package
// Shared constants, transaction types and sequencer states for the bounded
// set table and its slot memory.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;

    // Stored key width: the incoming key field carries 32 bits at most.
    localparam int KEY_W  = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] key;
    } t_in_item;

    typedef struct packed {
        logic       ok;
        logic       found;
        logic [5:0] position;
        logic [6:0] count;
        logic       empty_res;
    } t_out_item;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_DONE
    } t_state;

endpackage

[src/bst_slot_mem.sv]
// ----------------------------------------------------------------------------
// Bounded set table slot memory
// Single write port, single registered read port holding the stored keys.
// ----------------------------------------------------------------------------
module bst_slot_mem (
    input  logic                      i_clk,
    input  bst_pkg::t_mem_req         i_req,
    output logic [bst_pkg::KEY_W-1:0] o_rd_data
);
    import bst_pkg::*;

    logic [KEY_W-1:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_data <= r_mem[i_req.rd_addr];
        end
    end

endmodule

[src/bounded_set_table_unit.sv]
// ----------------------------------------------------------------------------
// Bounded set table unit
// Fixed-capacity set of distinct keys with insert, remove, lookup and clear,
// searched linearly through a slot memory by a small sequencer.
// ----------------------------------------------------------------------------
//   Channel   Direction   Signals                                Payload
//   input     in          i_in_valid, o_in_stall, i_in_data      t_in_item
//   output    out         o_out_valid, i_out_stall, o_out_data   t_out_item
//
// An item is searched one slot read and compared per cycle through the single
// memory read port; a successful remove then moves the last entry into the hole
// (a read, then a write), and the result is handed over from the done state.
// A clear skips the search. Reset empties the set at once; no clearing pass.
// A result waits in the output register while the next item is accepted; the
// sequencer holds in its final state only if that register is still full.
// ----------------------------------------------------------------------------
module bounded_set_table_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bst_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bst_pkg::t_out_item o_out_data
);
    import bst_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_out_valid, n_out_valid;

    t_opcode           r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_cmp_idx, n_cmp_idx;
    logic              r_ok, n_ok;
    logic              r_found, n_found;
    logic [ADDR_W-1:0] r_pos, n_pos;
    t_out_item         r_out, n_out;

    t_mem_req          mem_req;
    logic [KEY_W-1:0]  mem_rd_data;

    bst_slot_mem u_slot_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_ok      <= n_ok;
        r_found   <= n_found;
        r_pos     <= n_pos;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && i_out_stall;
        n_op        = r_op;
        n_key       = r_key;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_cmp_idx   = r_cmp_idx;
        n_ok        = r_ok;
        n_found     = r_found;
        n_pos       = r_pos;
        n_out       = r_out;
        mem_req     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_data.opcode;
                    n_key   = i_in_data.key[KEY_W-1:0];
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    n_pos   = '0;
                    if (i_in_data.opcode == OP_CLEAR) begin
                        n_fill  = '0;
                        n_ok    = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_ok    = 1'b0;
                        n_state = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // Read of one slot overlaps the compare of the slot before it.
                if (r_pend && (mem_rd_data == r_key)) begin
                    n_pend  = 1'b0;
                    n_found = 1'b1;
                    n_pos   = r_cmp_idx;
                    unique case (r_op)
                        OP_REMOVE: begin
                            n_ok    = 1'b1;
                            n_state = ST_MOVE_RD;
                        end
                        OP_LOOKUP: begin
                            n_ok    = 1'b1;
                            n_state = ST_DONE;
                        end
                        default: begin
                            n_ok    = 1'b0;
                            n_state = ST_DONE;
                        end
                    endcase
                end else if (r_idx < r_fill) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_idx[ADDR_W-1:0];
                    n_cmp_idx       = r_idx[ADDR_W-1:0];
                    n_idx           = r_idx + CNT_W'(1);
                    n_pend          = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_ok    = 1'b0;
                    if ((r_op == OP_INSERT) && (r_fill != CNT_W'(CAPACITY))) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = r_fill[ADDR_W-1:0];
                        mem_req.wr_data = r_key;
                        n_pos           = r_fill[ADDR_W-1:0];
                        n_fill          = r_fill + CNT_W'(1);
                        n_ok            = 1'b1;
                    end
                    n_state = ST_DONE;
                end
            end

            ST_MOVE_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ADDR_W'(r_fill - CNT_W'(1));
                n_state         = ST_MOVE_WR;
            end

            ST_MOVE_WR: begin
                // The last entry fills the hole left by the removed key.
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_pos;
                mem_req.wr_data = mem_rd_data;
                n_fill          = r_fill - CNT_W'(1);
                n_state         = ST_DONE;
            end

            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid     = 1'b1;
                    n_out.ok        = r_ok;
                    n_out.found     = r_found;
                    n_out.position  = 6'(32'(r_pos));
                    n_out.count     = 7'(32'(r_fill));
                    n_out.empty_res = (r_fill == '0);
                    n_state         = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.opcode == OP_CLEAR)) |=> (r_fill == '0))
        else $error("clear did not empty the set");

    a_move_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOVE_WR) |-> ($past(r_state) == ST_MOVE_RD))
        else $error("move write without preceding read");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOVE_WR) |=> (r_fill == $past(r_fill) - CNT_W'(1)))
        else $error("remove did not shrink the set by one");

endmodule
